### rtl/sector_chain_allocator_macros.svh
// assertion macros of the sector chain allocator, used by the sequencer
`ifndef SECTOR_CHAIN_ALLOCATOR_MACROS_SVH
`define SECTOR_CHAIN_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SCA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sector chain allocator check failed");
`define SCA_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sector chain allocator forbidden condition");
`else
`define SCA_ASSERT(lbl, clk, rst, prop)
`define SCA_NEVER(lbl, clk, rst, expr)
`endif
`endif

### rtl/sca_pkg.sv
// constants, types and helpers of the sector chain allocator
package sca_pkg;
   localparam int NUM_SECTORS = 1024;
   localparam int STAT_BYTES  = 64;
   localparam int SECT_W      = 11;
   localparam int ADDR_W      = $clog2(NUM_SECTORS);
   localparam int CNT_W       = $clog2(NUM_SECTORS + 1);
   localparam int SIZE_W      = 32;
   localparam int SB_W        = 13;
   localparam int SB_MIN      = 64;
   localparam int SB_MAX      = 4096;
   localparam int SB_RESET    = 1024;
   localparam int DIV_W       = 34;
   localparam int REM_W       = 13;
   localparam int DCNT_W      = $clog2(DIV_W);

   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_RESIZE = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BADSECT = 2'd2;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE          = 5'd0;
   localparam logic [OP_W-1:0] OP_CLEAR         = 5'd1;
   localparam logic [OP_W-1:0] OP_LOAD          = 5'd2;
   localparam logic [OP_W-1:0] OP_CREATE_RD     = 5'd3;
   localparam logic [OP_W-1:0] OP_CREATE_WR     = 5'd4;
   localparam logic [OP_W-1:0] OP_RES_NOSPACE   = 5'd5;
   localparam logic [OP_W-1:0] OP_RES_BAD       = 5'd6;
   localparam logic [OP_W-1:0] OP_RES_ZERO      = 5'd7;
   localparam logic [OP_W-1:0] OP_WALK_START    = 5'd8;
   localparam logic [OP_W-1:0] OP_WALK          = 5'd9;
   localparam logic [OP_W-1:0] OP_REMOVE        = 5'd10;
   localparam logic [OP_W-1:0] OP_DIV_STEP      = 5'd11;
   localparam logic [OP_W-1:0] OP_RES_GROW_FAIL = 5'd12;
   localparam logic [OP_W-1:0] OP_RES_EQUAL     = 5'd13;
   localparam logic [OP_W-1:0] OP_GROW_START    = 5'd14;
   localparam logic [OP_W-1:0] OP_GROW_STEP     = 5'd15;
   localparam logic [OP_W-1:0] OP_SHR_START     = 5'd16;
   localparam logic [OP_W-1:0] OP_SHR_STEP      = 5'd17;
   localparam logic [OP_W-1:0] OP_SHR_W1        = 5'd18;
   localparam logic [OP_W-1:0] OP_SHR_W2        = 5'd19;
   localparam logic [OP_W-1:0] OP_LOAD_RSP      = 5'd20;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       clr_done;
      logic       fh_ok;
      logic       fh_valid;
      logic       start_valid;
      logic       walk_more;
      logic       div_last;
      logic       cnt_gt_len;
      logic       cnt_lt_len;
      logic       need_gt_fc;
      logic       grow_more;
      logic       shr_more;
   } dp_stat_type;

   function automatic logic sect_ok(logic [SECT_W-1:0] s);
      return (s != '0) && (s <= SECT_W'(NUM_SECTORS));
   endfunction

   function automatic logic [ADDR_W-1:0] to_addr(logic [SECT_W-1:0] s);
      logic [SECT_W-1:0] d;
      d = s - SECT_W'(1);
      return d[ADDR_W-1:0];
   endfunction
endpackage

### rtl/sca_if.sv
// valid/ready channel interfaces for requests and responses
interface sca_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic [sca_pkg::SECT_W-1:0]    chain_start;
   logic [sca_pkg::SIZE_W-1:0]    new_size;
   modport source (output valid, output req_type, output chain_start, output new_size,
                   input ready);
   modport sink (input valid, input req_type, input chain_start, input new_size,
                 output ready);
endinterface

interface sca_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [sca_pkg::SECT_W-1:0]    sector;
   logic [sca_pkg::SECT_W-1:0]    chain_sectors;
   modport source (output valid, output status, output sector, output chain_sectors,
                   input ready);
   modport sink (input valid, input status, input sector, input chain_sectors,
                 output ready);
endinterface

### rtl/sector_chain_allocator.sv
// top level of the sector chain allocator
//
//   channel   dir   handshake      payload
//   req_ch    in    valid/ready    req_type, chain_start, new_size
//   rsp_ch    out   valid/ready    status, sector, chain_sectors
//   csr_*     in    write enable   sector_bytes
//
// after reset a clearing pass over all NUM_SECTORS entries builds the free list; no item is taken
// meanwhile. create pops the free head; a bad start or an unused type gives a result without a walk;
// remove walks the chain of L sectors; resize walks it and runs the 34-step divider (also out of
// space), then appends k sectors one by one, or walks to the cut and returns the tail
// one item is in work at a time; a finished result waits in the output register
// and the next item may be accepted while it is held by a stalled sink
module sector_chain_allocator (
   input  logic                      clock,
   input  logic                      reset,
   sca_req_if.sink                   req_ch,
   sca_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [sca_pkg::SB_W-1:0]  csr_wdata
);
   sca_pkg::dp_cmd_type  cmd;
   sca_pkg::dp_stat_type stat;

   // sequencer: one item at a time, result held until taken
   sca_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready)
   );

   // link table ram, free head and count, sector size divider
   sca_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .in_req_type(req_ch.req_type),
      .in_start(req_ch.chain_start),
      .in_size(req_ch.new_size),
      .out_status(rsp_ch.status),
      .out_sector(rsp_ch.sector),
      .out_owned(rsp_ch.chain_sectors)
   );
endmodule

### rtl/sca_ram.sv
// generic single write, single read ram with registered read
module sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/sca_datapath.sv
// link table, free list registers, divider and result registers
module sca_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  sca_pkg::dp_cmd_type        cmd,
   output sca_pkg::dp_stat_type       stat,
   input  logic                       csr_we,
   input  logic [sca_pkg::SB_W-1:0]   csr_wdata,
   input  logic [1:0]                 in_req_type,
   input  logic [sca_pkg::SECT_W-1:0] in_start,
   input  logic [sca_pkg::SIZE_W-1:0] in_size,
   output logic [1:0]                 out_status,
   output logic [sca_pkg::SECT_W-1:0] out_sector,
   output logic [sca_pkg::SECT_W-1:0] out_owned
);
   localparam int SW = sca_pkg::SECT_W;
   localparam int AW = sca_pkg::ADDR_W;
   localparam int CW = sca_pkg::CNT_W;
   localparam int DW = sca_pkg::DIV_W;
   localparam int RW = sca_pkg::REM_W;
   localparam int BW = sca_pkg::SB_W;
   localparam int N  = sca_pkg::NUM_SECTORS;

   logic [BW-1:0]   sb_ff;
   logic [AW-1:0]   clr_idx_ff;
   logic [SW-1:0]   fh_ff, fh_in;
   logic [CW-1:0]   fc_ff, fc_in;
   logic [1:0]      rtype_ff;
   logic [SW-1:0]   start_ff;
   logic [SW-1:0]   cur_ff, cur_in;
   logic [SW-1:0]   last_ff, last_in;
   logic [CW-1:0]   len_ff, len_in;
   logic [CW-1:0]   k_ff, k_in;
   logic [SW-1:0]   p_ff, p_in;
   logic [SW-1:0]   q_ff, q_in;
   logic [DW-1:0]   dvd_ff, dvd_in;
   logic [DW-1:0]   quot_ff, quot_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [sca_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [1:0]      res_st_ff, res_st_in;
   logic [SW-1:0]   res_sec_ff, res_sec_in;
   logic [SW-1:0]   res_own_ff, res_own_in;
   logic [1:0]      o_st_ff;
   logic [SW-1:0]   o_sec_ff, o_own_ff;

   logic            we;
   logic [AW-1:0]   waddr, raddr;
   logic [SW-1:0]   wdata, rdata;

   logic [BW-1:0]   sb_c;
   logic [DW-1:0]   cnt, need;
   logic [CW-1:0]   len_p1, k_p1, shr_diff;
   logic [CW:0]     fc_sum;
   logic [RW+1:0]   rem_sh;
   logic            walk_more, grow_more, shr_more;

   sca_ram #(.WIDTH(SW), .DEPTH(N)) u_link_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   always_comb begin
      if (sb_ff < BW'(sca_pkg::SB_MIN)) begin
         sb_c = BW'(sca_pkg::SB_MIN);
      end else if (sb_ff > BW'(sca_pkg::SB_MAX)) begin
         sb_c = BW'(sca_pkg::SB_MAX);
      end else begin
         sb_c = sb_ff;
      end
   end

   assign cnt       = (quot_ff == '0) ? DW'(1) : quot_ff;
   assign need      = cnt - DW'(len_ff);
   assign len_p1    = len_ff + CW'(1);
   assign k_p1      = k_ff + CW'(1);
   assign shr_diff  = len_ff - cnt[CW-1:0];
   assign walk_more = sca_pkg::sect_ok(rdata) && (len_p1 < CW'(N));
   assign grow_more = (DW'(k_p1) < need) && sca_pkg::sect_ok(rdata);
   assign shr_more  = DW'(k_ff) < cnt;
   assign rem_sh    = {1'b0, rem_ff, dvd_ff[DW-1]};

   always_comb begin
      stat.req_type    = rtype_ff;
      stat.clr_done    = clr_idx_ff == AW'(N - 1);
      stat.fh_ok       = sca_pkg::sect_ok(fh_ff) && (fc_ff != '0);
      stat.fh_valid    = sca_pkg::sect_ok(fh_ff);
      stat.start_valid = sca_pkg::sect_ok(start_ff);
      stat.walk_more   = walk_more;
      stat.div_last    = dcnt_ff == sca_pkg::DCNT_W'(DW - 1);
      stat.cnt_gt_len  = cnt > DW'(len_ff);
      stat.cnt_lt_len  = cnt < DW'(len_ff);
      stat.need_gt_fc  = need > DW'(fc_ff);
      stat.grow_more   = grow_more;
      stat.shr_more    = shr_more;
   end

   always_comb begin
      we = 1'b0;
      waddr = '0;
      wdata = '0;
      raddr = sca_pkg::to_addr(cur_ff);
      fh_in = fh_ff;
      fc_in = fc_ff;
      cur_in = cur_ff;
      last_in = last_ff;
      len_in = len_ff;
      k_in = k_ff;
      p_in = p_ff;
      q_in = q_ff;
      dvd_in = dvd_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      dcnt_in = dcnt_ff;
      res_st_in = res_st_ff;
      res_sec_in = res_sec_ff;
      res_own_in = res_own_ff;
      fc_sum = '0;
      unique case (cmd.op)
         sca_pkg::OP_CLEAR: begin
            // initial free list: each sector links the next one
            we = 1'b1;
            waddr = clr_idx_ff;
            wdata = (clr_idx_ff == AW'(N - 1)) ? '0 : SW'(clr_idx_ff) + SW'(2);
         end
         sca_pkg::OP_LOAD: begin
            dvd_in = DW'(in_size) + DW'(sca_pkg::STAT_BYTES) + DW'(sb_c) - DW'(1);
            quot_in = '0;
            rem_in = '0;
            dcnt_in = '0;
         end
         sca_pkg::OP_CREATE_RD: begin
            raddr = sca_pkg::to_addr(fh_ff);
         end
         sca_pkg::OP_CREATE_WR: begin
            we = 1'b1;
            waddr = sca_pkg::to_addr(fh_ff);
            fh_in = rdata;
            fc_in = fc_ff - CW'(1);
            res_st_in = sca_pkg::ST_OK;
            res_sec_in = fh_ff;
            res_own_in = SW'(1);
         end
         sca_pkg::OP_RES_NOSPACE: begin
            res_st_in = sca_pkg::ST_NOSPACE;
            res_sec_in = '0;
            res_own_in = '0;
         end
         sca_pkg::OP_RES_BAD: begin
            res_st_in = sca_pkg::ST_BADSECT;
            res_sec_in = start_ff;
            res_own_in = '0;
         end
         sca_pkg::OP_RES_ZERO: begin
            res_st_in = sca_pkg::ST_OK;
            res_sec_in = '0;
            res_own_in = '0;
         end
         sca_pkg::OP_WALK_START: begin
            raddr = sca_pkg::to_addr(start_ff);
            cur_in = start_ff;
            len_in = '0;
         end
         sca_pkg::OP_WALK: begin
            len_in = len_p1;
            last_in = cur_ff;
            if (walk_more) begin
               cur_in = rdata;
               raddr = sca_pkg::to_addr(rdata);
            end
         end
         sca_pkg::OP_REMOVE: begin
            // whole chain goes to the free head in order
            we = 1'b1;
            waddr = sca_pkg::to_addr(last_ff);
            wdata = fh_ff;
            fh_in = start_ff;
            fc_sum = {1'b0, fc_ff} + {1'b0, len_ff};
            fc_in = (fc_sum > (CW+1)'(N)) ? CW'(N) : fc_sum[CW-1:0];
            res_st_in = sca_pkg::ST_OK;
            res_sec_in = start_ff;
            res_own_in = '0;
         end
         sca_pkg::OP_DIV_STEP: begin
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
            if (rem_sh >= (RW+2)'(sb_c)) begin
               rem_in = RW'(rem_sh - (RW+2)'(sb_c));
               quot_in = {quot_ff[DW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[RW-1:0];
               quot_in = {quot_ff[DW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + sca_pkg::DCNT_W'(1);
         end
         sca_pkg::OP_RES_GROW_FAIL: begin
            res_st_in = sca_pkg::ST_NOSPACE;
            res_sec_in = start_ff;
            res_own_in = SW'(len_ff);
         end
         sca_pkg::OP_RES_EQUAL: begin
            res_st_in = sca_pkg::ST_OK;
            res_sec_in = start_ff;
            res_own_in = SW'(len_ff);
         end
         sca_pkg::OP_GROW_START: begin
            we = 1'b1;
            waddr = sca_pkg::to_addr(last_ff);
            raddr = sca_pkg::to_addr(fh_ff);
            cur_in = fh_ff;
            k_in = '0;
            res_st_in = sca_pkg::ST_OK;
            res_sec_in = start_ff;
            res_own_in = SW'(len_ff);
            if (sca_pkg::sect_ok(fh_ff)) begin
               wdata = fh_ff;
            end else begin
               wdata = '0;
            end
         end
         sca_pkg::OP_GROW_STEP: begin
            k_in = k_p1;
            if (grow_more) begin
               cur_in = rdata;
               raddr = sca_pkg::to_addr(rdata);
            end else begin
               // last sector taken closes the chain
               we = 1'b1;
               waddr = sca_pkg::to_addr(cur_ff);
               wdata = '0;
               fh_in = rdata;
               fc_in = (fc_ff > k_p1) ? fc_ff - k_p1 : '0;
               res_own_in = SW'(len_ff + k_p1);
            end
         end
         sca_pkg::OP_SHR_START: begin
            raddr = sca_pkg::to_addr(start_ff);
            cur_in = start_ff;
            k_in = CW'(1);
         end
         sca_pkg::OP_SHR_STEP: begin
            if (shr_more) begin
               cur_in = rdata;
               raddr = sca_pkg::to_addr(rdata);
               k_in = k_p1;
            end else begin
               p_in = cur_ff;
               q_in = rdata;
            end
         end
         sca_pkg::OP_SHR_W1: begin
            // tail keeps its order on the free list, ending at the old head
            we = 1'b1;
            waddr = sca_pkg::to_addr(last_ff);
            wdata = fh_ff;
            fh_in = q_ff;
         end
         sca_pkg::OP_SHR_W2: begin
            we = 1'b1;
            waddr = sca_pkg::to_addr(p_ff);
            wdata = '0;
            fc_sum = {1'b0, fc_ff} + {1'b0, shr_diff};
            fc_in = (fc_sum > (CW+1)'(N)) ? CW'(N) : fc_sum[CW-1:0];
            res_st_in = sca_pkg::ST_OK;
            res_sec_in = start_ff;
            res_own_in = SW'(cnt[CW-1:0]);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff <= BW'(sca_pkg::SB_RESET);
         clr_idx_ff <= '0;
         fh_ff <= SW'(1);
         fc_ff <= CW'(N);
      end else begin
         if (csr_we) begin
            sb_ff <= csr_wdata;
         end
         if (cmd.op == sca_pkg::OP_CLEAR) begin
            clr_idx_ff <= clr_idx_ff + AW'(1);
         end
         fh_ff <= fh_in;
         fc_ff <= fc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == sca_pkg::OP_LOAD) begin
         rtype_ff <= in_req_type;
         start_ff <= in_start;
      end
      if (cmd.op == sca_pkg::OP_LOAD_RSP) begin
         o_st_ff <= res_st_ff;
         o_sec_ff <= res_sec_ff;
         o_own_ff <= res_own_ff;
      end
      cur_ff <= cur_in;
      last_ff <= last_in;
      len_ff <= len_in;
      k_ff <= k_in;
      p_ff <= p_in;
      q_ff <= q_in;
      dvd_ff <= dvd_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dcnt_ff <= dcnt_in;
      res_st_ff <= res_st_in;
      res_sec_ff <= res_sec_in;
      res_own_ff <= res_own_in;
   end

   assign out_status = o_st_ff;
   assign out_sector = o_sec_ff;
   assign out_owned  = o_own_ff;
endmodule

### rtl/sca_ctrl.sv
// request sequencer driving the datapath
`include "sector_chain_allocator_macros.svh"
module sca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   output sca_pkg::dp_cmd_type   cmd,
   input  sca_pkg::dp_stat_type  stat,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready
);
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_CREATE   = 4'd3;
   localparam logic [3:0] S_WALK     = 4'd4;
   localparam logic [3:0] S_REMOVE   = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_EVAL     = 4'd7;
   localparam logic [3:0] S_GROW_ST  = 4'd8;
   localparam logic [3:0] S_GROW     = 4'd9;
   localparam logic [3:0] S_SHR      = 4'd10;
   localparam logic [3:0] S_SHR_W1   = 4'd11;
   localparam logic [3:0] S_SHR_W2   = 4'd12;
   localparam logic [3:0] S_FINISH   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op = sca_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = sca_pkg::OP_CLEAR;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = sca_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (stat.req_type == sca_pkg::REQ_CREATE) begin
               if (stat.fh_ok) begin
                  cmd.op = sca_pkg::OP_CREATE_RD;
                  state_in = S_CREATE;
               end else begin
                  cmd.op = sca_pkg::OP_RES_NOSPACE;
                  state_in = S_FINISH;
               end
            end else if (stat.req_type == sca_pkg::REQ_RESIZE ||
                         stat.req_type == sca_pkg::REQ_REMOVE) begin
               if (stat.start_valid) begin
                  cmd.op = sca_pkg::OP_WALK_START;
                  state_in = S_WALK;
               end else begin
                  cmd.op = sca_pkg::OP_RES_BAD;
                  state_in = S_FINISH;
               end
            end else begin
               cmd.op = sca_pkg::OP_RES_ZERO;
               state_in = S_FINISH;
            end
         end
         S_CREATE: begin
            cmd.op = sca_pkg::OP_CREATE_WR;
            state_in = S_FINISH;
         end
         S_WALK: begin
            cmd.op = sca_pkg::OP_WALK;
            if (!stat.walk_more) begin
               state_in = (stat.req_type == sca_pkg::REQ_REMOVE) ? S_REMOVE : S_DIV;
            end
         end
         S_REMOVE: begin
            cmd.op = sca_pkg::OP_REMOVE;
            state_in = S_FINISH;
         end
         S_DIV: begin
            cmd.op = sca_pkg::OP_DIV_STEP;
            if (stat.div_last) state_in = S_EVAL;
         end
         S_EVAL: begin
            priority if (stat.cnt_gt_len) begin
               if (stat.need_gt_fc) begin
                  cmd.op = sca_pkg::OP_RES_GROW_FAIL;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_GROW_ST;
               end
            end else if (stat.cnt_lt_len) begin
               cmd.op = sca_pkg::OP_SHR_START;
               state_in = S_SHR;
            end else begin
               cmd.op = sca_pkg::OP_RES_EQUAL;
               state_in = S_FINISH;
            end
         end
         S_GROW_ST: begin
            cmd.op = sca_pkg::OP_GROW_START;
            state_in = stat.fh_valid ? S_GROW : S_FINISH;
         end
         S_GROW: begin
            cmd.op = sca_pkg::OP_GROW_STEP;
            if (!stat.grow_more) state_in = S_FINISH;
         end
         S_SHR: begin
            cmd.op = sca_pkg::OP_SHR_STEP;
            if (!stat.shr_more) state_in = S_SHR_W1;
         end
         S_SHR_W1: begin
            cmd.op = sca_pkg::OP_SHR_W1;
            state_in = S_SHR_W2;
         end
         S_SHR_W2: begin
            cmd.op = sca_pkg::OP_SHR_W2;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.op = sca_pkg::OP_LOAD_RSP;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SCA_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
   `SCA_ASSERT(a_clear_once, clock, reset, (state_ff != S_CLEAR) |=> (state_ff != S_CLEAR))
   `SCA_NEVER(a_no_overwrite, clock, reset, (cmd.op == sca_pkg::OP_LOAD_RSP) && !out_free)
endmodule

### bench/sector_chain_allocator_tb.sv
// self-checking testbench of the sector chain allocator with a link-table predictor
module sector_chain_allocator_tb;
   localparam int SECT_W      = sca_pkg::SECT_W;
   localparam int NUM_SECTORS = sca_pkg::NUM_SECTORS;
   localparam int STAT_BYTES  = sca_pkg::STAT_BYTES;
   localparam int SB_W        = sca_pkg::SB_W;
   localparam int SB_MIN      = sca_pkg::SB_MIN;
   localparam int SB_MAX      = sca_pkg::SB_MAX;
   localparam int SB_RESET    = sca_pkg::SB_RESET;
   localparam logic [1:0] REQ_CREATE = sca_pkg::REQ_CREATE;
   localparam logic [1:0] REQ_RESIZE = sca_pkg::REQ_RESIZE;
   localparam logic [1:0] REQ_REMOVE = sca_pkg::REQ_REMOVE;
   localparam logic [1:0] ST_OK      = sca_pkg::ST_OK;
   localparam logic [1:0] ST_NOSPACE = sca_pkg::ST_NOSPACE;
   localparam logic [1:0] ST_BADSECT = sca_pkg::ST_BADSECT;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]        status;
      logic [SECT_W-1:0] sector;
      logic [SECT_W-1:0] owned;
   } alloc_result_type;

   // link table mirror and the chain results it predicts
   class chain_scoreboard;
      logic [SECT_W-1:0] link_tbl[NUM_SECTORS];
      int unsigned       walk[NUM_SECTORS];
      int unsigned       free_head;
      int unsigned       free_count;
      int unsigned       sec_size;
      int                heads[$];
      alloc_result_type  pending_results[$];
      int                errors;
      int                checked;

      function new();
         for (int i = 0; i < NUM_SECTORS; i++)
            link_tbl[i] = (i + 1 < NUM_SECTORS) ? SECT_W'(i + 2) : '0;
         free_head  = 1;
         free_count = NUM_SECTORS;
         sec_size   = SB_RESET;
         errors     = 0;
         checked    = 0;
      endfunction

      function bit in_range(int unsigned s);
         return s >= 1 && s <= NUM_SECTORS;
      endfunction

      function void release_sector(int unsigned s);
         link_tbl[s-1] = SECT_W'(free_head);
         free_head = s;
         if (free_count < NUM_SECTORS) free_count++;
      endfunction

      function void note(logic [1:0] kind, logic [SECT_W-1:0] start, logic [31:0] nsz);
         alloc_result_type r;
         int unsigned len, tail, i, s;
         longint unsigned sb, cnt, need;
         r = '{ST_OK, '0, '0};
         if (kind == REQ_CREATE) begin
            if (!in_range(free_head) || free_count == 0) begin
               r.status = ST_NOSPACE;
            end else begin
               r.sector = SECT_W'(free_head);
               s = free_head;
               free_head = link_tbl[s-1];
               link_tbl[s-1] = '0;
               free_count--;
               r.owned = 1;
               heads = {heads, s};
            end
         end else if (kind == REQ_RESIZE || kind == REQ_REMOVE) begin
            r.sector = start;
            if (!in_range(start)) begin
               r.status = ST_BADSECT;
            end else begin
               // walk to link 0, capped at the table size
               len = 0;
               s = start;
               while (in_range(s) && len < NUM_SECTORS) begin
                  walk[len++] = s;
                  s = link_tbl[s-1];
               end
               sb = sec_size < SB_MIN ? SB_MIN : (sec_size > SB_MAX ? SB_MAX : sec_size);
               if (kind == REQ_RESIZE) begin
                  cnt = (longint'(nsz) + STAT_BYTES + sb - 1) / sb;
                  if (cnt < 1) cnt = 1;
               end else begin
                  cnt = 1;
               end
               if (cnt > len) begin
                  need = cnt - len;
                  if (need > free_count) begin
                     r.status = ST_NOSPACE;
                     r.owned  = SECT_W'(len);
                  end else begin
                     tail = walk[len-1];
                     for (i = 0; i < need && in_range(free_head); i++) begin
                        link_tbl[tail-1] = SECT_W'(free_head);
                        tail = free_head;
                        free_head = link_tbl[tail-1];
                        if (free_count > 0) free_count--;
                     end
                     link_tbl[tail-1] = '0;
                     r.owned = SECT_W'(len + i);
                  end
               end else if (cnt < len) begin
                  // tail sectors go back last first
                  for (i = len; i > cnt; i--) release_sector(walk[i-1]);
                  link_tbl[walk[cnt-1]-1] = '0;
                  r.owned = SECT_W'(cnt);
               end else begin
                  r.owned = SECT_W'(len);
               end
               if (r.status == ST_OK && kind == REQ_REMOVE) begin
                  release_sector(start);
                  r.owned = '0;
                  foreach (heads[k]) if (heads[k] == start) begin
                     heads.delete(k);
                     break;
                  end
               end
            end
         end
         pending_results = {pending_results, r};
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check(logic [1:0] st, logic [SECT_W-1:0] sec, logic [SECT_W-1:0] own);
         alloc_result_type e;
         checked++;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result status %0d sector %0d", st, sec));
            return;
         end
         e = pending_results.pop_front();
         if (st !== e.status)
            report($sformatf("status %0d, want %0d (sector %0d)", st, e.status, e.sector));
         if (sec !== e.sector)
            report($sformatf("sector %0d, want %0d", sec, e.sector));
         if (own !== e.owned)
            report($sformatf("chain_sectors %0d, want %0d (sector %0d)", own, e.owned, e.sector));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [SB_W-1:0] csr_wdata;
   int tx_idle_pct;
   int rx_stall_pct;
   chain_scoreboard sb;

   sca_req_if req_if();
   sca_rsp_if rsp_if();

   sector_chain_allocator dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check(rsp_if.status, rsp_if.sector, rsp_if.chain_sectors);
   end

   // present one item, hold it until taken, then maybe idle
   task automatic send_item(logic [1:0] kind, logic [SECT_W-1:0] start, logic [31:0] nsz,
                            bit last);
      int gap;
      req_if.valid       <= 1'b1;
      req_if.req_type    <= kind;
      req_if.chain_start <= start;
      req_if.new_size    <= nsz;
      do @(posedge clock); while (!req_if.ready);
      sb.note(kind, start, nsz);
      gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0 || last) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic set_sector_bytes(logic [SB_W-1:0] v);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.sec_size = v;
   endtask

   task automatic random_item(bit last);
      int pick, szsel, h;
      int unsigned sbv;
      logic [31:0] nsz;
      sbv = sb.sec_size < SB_MIN ? SB_MIN : (sb.sec_size > SB_MAX ? SB_MAX : sb.sec_size);
      szsel = $urandom_range(99);
      if (szsel < 70)      nsz = $urandom_range(0, 6 * sbv);
      else if (szsel < 85) nsz = $urandom_range(0, 64);
      else if (szsel < 95) nsz = $urandom();
      else                 nsz = 32'hFFFF_FFFF;
      pick = $urandom_range(99);
      if (sb.heads.size() == 0 || pick < 20 || (sb.heads.size() < 4 && pick < 40)) begin
         send_item(REQ_CREATE, SECT_W'($urandom()), $urandom(), last);
      end else if (pick < 90) begin
         h = sb.heads[$urandom_range(sb.heads.size() - 1)];
         // remove more often when many chains are live
         if (pick >= 75 || (sb.heads.size() > 40 && pick >= 55))
            send_item(REQ_REMOVE, SECT_W'(h), $urandom(), last);
         else
            send_item(REQ_RESIZE, SECT_W'(h), nsz, last);
      end else if (pick < 95) begin
         send_item(pick[0] ? REQ_RESIZE : REQ_REMOVE,
                   pick[1] ? SECT_W'(0) : SECT_W'($urandom_range(NUM_SECTORS + 1, 2047)),
                   nsz, last);
      end else begin
         send_item(REQ_UNUSED, SECT_W'($urandom()), $urandom(), last);
      end
   endtask

   initial begin
      logic [SB_W-1:0] phase_cfg[6];
      int c1, c2, c3;
      phase_cfg = '{13'd64, 13'd4096, 13'd100, 13'd0, 13'd8191, 13'd1024};
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      req_if.valid = 1'b0;
      req_if.req_type = REQ_CREATE;
      req_if.chain_start = '0;
      req_if.new_size = '0;
      rsp_if.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: whole disk in one chain, exhaustion, bad sectors, shrink and remove
      send_item(REQ_UNUSED, 11'h7FF, 32'hFFFF_FFFF, 0);
      send_item(REQ_CREATE, '0, '0, 0);
      send_item(REQ_RESIZE, 11'd1, 32'd0, 0);
      send_item(REQ_RESIZE, 11'd1, 32'd1024 * 1024 - STAT_BYTES, 0);
      send_item(REQ_CREATE, '0, '0, 0);
      send_item(REQ_RESIZE, 11'd1, 32'd1024 * 1024 - STAT_BYTES + 1, 0);
      send_item(REQ_RESIZE, 11'd1, 32'hFFFF_FFFF, 0);
      send_item(REQ_RESIZE, 11'd1, 32'd2000, 0);
      send_item(REQ_REMOVE, 11'd0, '0, 0);
      send_item(REQ_REMOVE, 11'd1025, '0, 0);
      send_item(REQ_RESIZE, 11'h7FF, 32'd5, 0);
      send_item(REQ_REMOVE, 11'd1, '0, 0);
      send_item(REQ_CREATE, '0, '0, 0);
      c1 = sb.heads[$];
      send_item(REQ_CREATE, '0, '0, 0);
      c2 = sb.heads[$];
      send_item(REQ_CREATE, '0, '0, 0);
      c3 = sb.heads[$];
      send_item(REQ_RESIZE, SECT_W'(c1), 32'd5000, 0);
      send_item(REQ_RESIZE, SECT_W'(c2), 32'd3000, 0);
      send_item(REQ_RESIZE, SECT_W'(c1), 32'd960, 0);
      send_item(REQ_REMOVE, SECT_W'(c2), '0, 0);
      send_item(REQ_RESIZE, SECT_W'(c3), 32'd1, 1);

      // random phases across sector sizes and idle patterns
      for (int p = 0; p < 6; p++) begin
         set_sector_bytes(phase_cfg[p]);
         tx_idle_pct  = (p % 4 == 1) ? 67 : ((p % 4 == 3) ? 21 : 0);
         rx_stall_pct = (p % 4 == 2) ? 67 : ((p % 4 == 3) ? 21 : 0);
         for (int n = 0; n < 190; n++) random_item(n == 189);
      end

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("checked %0d results over six sector sizes and four idle patterns",
               sb.checked);
      $display("%0d live chains, %0d free sectors at the end", sb.heads.size(), sb.free_count);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #200000000;
      $display("timeout with %0d results outstanding", sb.pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
